/* design/gda_pkg.sv */
// Shared types, constants and a helper function of the grid direction angle block.
package gda_pkg;

  localparam int COORD_W = 32;
  localparam int ANGLE_W = 16;
  localparam int ROW_W   = 16;
  localparam int COL_W   = 10;
  localparam int DP_W    = 64;
  localparam int Z_W     = 34;
  localparam int STEPS   = 31;
  localparam int NORM_TOP = 58;

  localparam logic signed [Z_W-1:0] ATAN_TAB [0:STEPS-1] = '{
    34'sh020000000, 34'sh012E4051E, 34'sh009FB385B, 34'sh0051111D4, 34'sh0028B0D43,
    34'sh00145D7E1, 34'sh000A2F61E, 34'sh000517C55, 34'sh00028BE53, 34'sh000145F2F,
    34'sh0000A2F98, 34'sh0000517CC, 34'sh000028BE6, 34'sh0000145F3, 34'sh00000A2FA,
    34'sh00000517D, 34'sh0000028BE, 34'sh00000145F, 34'sh000000A30, 34'sh000000518,
    34'sh00000028C, 34'sh000000146, 34'sh0000000A3, 34'sh000000051, 34'sh000000029,
    34'sh000000014, 34'sh00000000A, 34'sh000000005, 34'sh000000003, 34'sh000000001,
    34'sh000000001
  };

  typedef enum logic [1:0] {
    CFG_LAST_COLUMN = 2'd0,
    CFG_LAST_ROW    = 2'd1,
    CFG_WANT_E1     = 2'd2,
    CFG_WANT_E2     = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PREP,
    ST_WAIT,
    ST_SEND
  } seq_state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic                      first_point;
  } in_t;

  typedef struct packed {
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          column;
    logic signed [ANGLE_W-1:0] angle_e1;
    logic signed [ANGLE_W-1:0] angle_e2;
    logic                      e1_valid;
    logic                      e2_valid;
    logic                      last_of_run;
  } out_t;

  // Control bits that travel along the rotation chain with each job.
  typedef struct packed {
    logic valid;
    logic dir;
    logic zero;
  } job_meta_t;

  function automatic logic [1:0] slot_add(logic [1:0] s, logic [1:0] k);
    logic [2:0] sum;
    sum = {1'b0, s} + {1'b0, k};
    if (sum >= 3'd3) begin
      sum = sum - 3'd3;
    end
    return sum[1:0];
  endfunction

endpackage

/* design/gda_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module gda_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 3072
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/gda_cell.sv */
// One vectoring rotation step of the angle chain, registered toward its neighbor.
module gda_cell import gda_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  job_meta_t              meta_i,
  input  logic signed [DP_W-1:0] x_i,
  input  logic signed [DP_W-1:0] y_i,
  input  logic signed [Z_W-1:0]  z_i,
  output job_meta_t              meta_o,
  output logic signed [DP_W-1:0] x_o,
  output logic signed [DP_W-1:0] y_o,
  output logic signed [Z_W-1:0]  z_o
);

  job_meta_t              meta_q;
  logic signed [DP_W-1:0] x_q, y_q, x_d, y_d, xs, ys;
  logic signed [Z_W-1:0]  z_q, z_d;

  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    if (y_i > 0) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN_TAB[STEP];
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN_TAB[STEP];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else begin
      meta_q <= meta_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign meta_o = meta_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

/* design/grid_direction_angle.sv */
// Top level of the grid direction angle block: line store, sequencer and rotation chain.
// Grid points arrive in raster order and are written into a three-row line store. Each
// accepted point releases zero to four results, the points one row and one column behind,
// plus the last row as it arrives. Each result passes through line store reads on the
// single read port, two operand normalizations, the rotation chain, collection of the
// second angle and the transfer itself, which waits while the output is stalled. Points
// are accepted only while no earlier result is open.
module grid_direction_angle import gda_pkg::*; #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int AW   = $clog2(3 * MAX_COLUMNS);
  localparam int DW   = 2 * COORD_W;
  localparam int LCAP = (MAX_COLUMNS - 1 < 1023) ? MAX_COLUMNS - 1 : 1023;
  localparam int SH   = 32 - ANGLE_W;
  localparam logic signed [Z_W:0] RND = (Z_W+1)'(64'sd1 <<< (SH - 1));
  localparam logic signed [Z_W:0] HI  = (Z_W+1)'((64'sd1 <<< (ANGLE_W - 1)) - 1);
  localparam logic signed [Z_W:0] LO  = -HI - 1;

  function automatic logic [AW-1:0] addr_of(logic [1:0] s, logic [COL_W-1:0] c);
    logic [AW-1:0] base;
    case (s)
      2'd1:    base = AW'(MAX_COLUMNS);
      2'd2:    base = AW'(2 * MAX_COLUMNS);
      default: base = '0;
    endcase
    return base + AW'(c);
  endfunction

  // Configuration registers.
  logic [COL_W-1:0] last_col_q;
  logic [ROW_W-1:0] last_row_q;
  logic             want_e1_q, want_e2_q;
  logic [COL_W-1:0] lc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= COL_W'(1023);
      last_row_q <= ROW_W'(1);
      want_e1_q  <= 1'b1;
      want_e2_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LAST_COLUMN: last_col_q <= cfg_wdata_i[COL_W-1:0];
        CFG_LAST_ROW:    last_row_q <= cfg_wdata_i[ROW_W-1:0];
        CFG_WANT_E1:     want_e1_q  <= cfg_wdata_i[0];
        CFG_WANT_E2:     want_e2_q  <= cfg_wdata_i[0];
        default:         last_col_q <= last_col_q;
      endcase
    end
  end

  assign lc = (last_col_q < COL_W'(LCAP)) ? last_col_q : COL_W'(LCAP);

  seq_state_e state_q, state_d;

  // Position tracking at input transfer.
  logic [ROW_W-1:0] row_q, it_row_q, a_row, n_row;
  logic [COL_W-1:0] col_q, it_col_q, a_col, n_col;
  logic [1:0]       slot_q, it_slot_q, a_slot;
  logic [3:0]       mask_q, a_mask, low_bit, rest_mask;
  logic             in_xfer, out_xfer, a_up, a_dn;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_o && !out_stall_i;

  always_comb begin
    a_row  = in_data_i.first_point ? '0 : row_q;
    a_col  = in_data_i.first_point ? '0 : col_q;
    a_slot = (a_col == '0) ? slot_add(slot_q, 2'd1) : slot_q;
    a_up   = (a_row != '0) && ((a_row - ROW_W'(1)) < last_row_q);
    a_dn   = (a_row >= last_row_q);
    a_mask = {a_dn && (a_col == lc), a_dn && (a_col != '0),
              a_up && (a_col == lc), a_up && (a_col != '0)};
    if (a_col >= lc) begin
      n_col = '0;
      n_row = (a_row >= last_row_q) ? '0 : a_row + ROW_W'(1);
    end else begin
      n_col = a_col + COL_W'(1);
      n_row = a_row;
    end
  end

  // Current result, chosen as the lowest pending one.
  logic [ROW_W-1:0] r_cur;
  logic [COL_W-1:0] c_cur, c_hi, c_lo;
  logic [1:0]       s_cur, s_nxt, s_prv, s_hs, s_ls;

  always_comb begin
    low_bit   = mask_q & (~mask_q + 4'd1);
    rest_mask = mask_q & ~low_bit;
    if (low_bit[0] || low_bit[1]) begin
      r_cur = it_row_q - ROW_W'(1);
      s_cur = slot_add(it_slot_q, 2'd2);
      s_nxt = it_slot_q;
      s_prv = slot_add(it_slot_q, 2'd1);
    end else begin
      r_cur = it_row_q;
      s_cur = it_slot_q;
      s_nxt = it_slot_q;
      s_prv = slot_add(it_slot_q, 2'd2);
    end
    c_cur = (low_bit[0] || low_bit[2]) ? it_col_q - COL_W'(1) : lc;
    c_hi  = (c_cur < lc) ? c_cur + COL_W'(1) : c_cur;
    c_lo  = (c_cur != '0) ? c_cur - COL_W'(1) : c_cur;
    s_hs  = (r_cur < last_row_q) ? s_nxt : s_cur;
    s_ls  = (r_cur != '0) ? s_prv : s_cur;
  end

  // Line store.
  logic [2:0]    rd_cnt_q;
  logic [AW-1:0] raddr;
  logic [DW-1:0] rdata;
  logic [DW-1:0] pt_q [4];

  always_comb begin
    case (rd_cnt_q[1:0])
      2'd0:    raddr = addr_of(s_cur, c_hi);
      2'd1:    raddr = addr_of(s_cur, c_lo);
      2'd2:    raddr = addr_of(s_hs, c_cur);
      default: raddr = addr_of(s_ls, c_cur);
    endcase
  end

  gda_ram #(
    .WIDTH(DW),
    .DEPTH(3 * MAX_COLUMNS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (in_xfer),
    .waddr_i(addr_of(a_slot, a_col)),
    .wdata_i({in_data_i.x_coord, in_data_i.y_coord}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Operand preparation: difference, half-plane fold and normalizing shift.
  logic                      job_q, nzero_q;
  logic [2:0]                ncnt_q, done_q;
  logic signed [DP_W-1:0]    nx_q, ny_q, dx, dy, lx, ly;
  logic [DP_W-1:0]           nm_q, lm;
  logic signed [Z_W-1:0]     nz_q, lz;
  logic signed [COORD_W-1:0] ax, ay, bx, by;
  logic [5:0]                nsh;

  always_comb begin
    if (!job_q) begin
      {ax, ay} = pt_q[0];
      {bx, by} = pt_q[1];
    end else begin
      {ax, ay} = pt_q[2];
      {bx, by} = pt_q[3];
    end
    dx = DP_W'(ax) - DP_W'(bx);
    dy = DP_W'(ay) - DP_W'(by);
    if (dx < 0) begin
      lx = -dx;
      ly = -dy;
      lz = (dy >= 0) ? (Z_W'(64'sd1 <<< 31)) : -(Z_W'(64'sd1 <<< 31));
    end else begin
      lx = dx;
      ly = dy;
      lz = '0;
    end
    lm = DP_W'(lx) | ((ly < 0) ? DP_W'(-ly) : DP_W'(ly));
    case (ncnt_q)
      3'd1:    nsh = 6'd32;
      3'd2:    nsh = 6'd16;
      3'd3:    nsh = 6'd8;
      3'd4:    nsh = 6'd4;
      3'd5:    nsh = 6'd2;
      default: nsh = 6'd1;
    endcase
  end

  // Rotation chain.
  job_meta_t              ch_meta [STEPS+1];
  logic signed [DP_W-1:0] ch_x [STEPS+1];
  logic signed [DP_W-1:0] ch_y [STEPS+1];
  logic signed [Z_W-1:0]  ch_z [STEPS+1];

  assign ch_meta[0] = '{valid: (state_q == ST_PREP) && (ncnt_q == 3'd7),
                        dir: job_q, zero: nzero_q};
  assign ch_x[0] = nx_q;
  assign ch_y[0] = ny_q;
  assign ch_z[0] = nz_q;

  for (genvar i = 0; i < STEPS; i++) begin : g_chain
    gda_cell #(.STEP(i)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .meta_i(ch_meta[i]),
      .x_i   (ch_x[i]),
      .y_i   (ch_y[i]),
      .z_i   (ch_z[i]),
      .meta_o(ch_meta[i+1]),
      .x_o   (ch_x[i+1]),
      .y_o   (ch_y[i+1]),
      .z_o   (ch_z[i+1])
    );
  end

  // Rounding and saturation of the chain result.
  logic signed [Z_W:0]       zr;
  logic signed [ANGLE_W-1:0] ang, a1_q, a2_q;

  always_comb begin
    zr = ((Z_W+1)'(ch_z[STEPS]) + RND) >>> SH;
    if (ch_meta[STEPS].zero) begin
      ang = '0;
    end else if (zr > HI) begin
      ang = HI[ANGLE_W-1:0];
    end else if (zr < LO) begin
      ang = LO[ANGLE_W-1:0];
    end else begin
      ang = zr[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ch_meta[STEPS].valid) begin
      if (ch_meta[STEPS].dir) begin
        a2_q <= ang;
      end else begin
        a1_q <= ang;
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_xfer && (a_mask != '0)) state_d = ST_READ;
      ST_READ: if (rd_cnt_q == 3'd4) state_d = ST_PREP;
      ST_PREP: if ((ncnt_q == 3'd7) && job_q) state_d = ST_WAIT;
      ST_WAIT: if (done_q == 3'd2) state_d = ST_SEND;
      ST_SEND: begin
        if (!out_stall_i) begin
          state_d = (rest_mask != '0) ? ST_READ : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      row_q    <= '0;
      col_q    <= '0;
      slot_q   <= '0;
      mask_q   <= '0;
      rd_cnt_q <= '0;
      ncnt_q   <= '0;
      job_q    <= 1'b0;
      done_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        row_q  <= n_row;
        col_q  <= n_col;
        slot_q <= a_slot;
        mask_q <= a_mask;
      end
      if (out_xfer) begin
        mask_q <= rest_mask;
      end
      if (state_q == ST_READ) begin
        rd_cnt_q <= rd_cnt_q + 3'd1;
      end else begin
        rd_cnt_q <= '0;
      end
      if (state_q == ST_PREP) begin
        ncnt_q <= ncnt_q + 3'd1;
        if (ncnt_q == 3'd7) begin
          job_q <= ~job_q;
        end
      end else begin
        ncnt_q <= '0;
        job_q  <= 1'b0;
      end
      if (state_q == ST_READ) begin
        done_q <= '0;
      end else if (ch_meta[STEPS].valid) begin
        done_q <= done_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      it_row_q  <= a_row;
      it_col_q  <= a_col;
      it_slot_q <= a_slot;
    end
    if ((state_q == ST_READ) && (rd_cnt_q != '0)) begin
      pt_q[rd_cnt_q[1:0] - 2'd1] <= rdata;
    end
    if (state_q == ST_PREP) begin
      if (ncnt_q == 3'd0) begin
        nx_q    <= lx;
        ny_q    <= ly;
        nz_q    <= lz;
        nm_q    <= lm;
        nzero_q <= (dx == 0) && (dy == 0);
      end else if (ncnt_q != 3'd7) begin
        if ((nm_q >> (NORM_TOP + 1 - int'(nsh))) == '0) begin
          nx_q <= nx_q <<< nsh;
          ny_q <= ny_q <<< nsh;
          nm_q <= nm_q << nsh;
        end
      end
    end
  end

  assign out_valid_o            = (state_q == ST_SEND);
  assign out_data_o.row         = r_cur;
  assign out_data_o.column      = c_cur;
  assign out_data_o.angle_e1    = want_e1_q ? a1_q : '0;
  assign out_data_o.angle_e2    = want_e2_q ? a2_q : '0;
  assign out_data_o.e1_valid    = want_e1_q;
  assign out_data_o.e2_valid    = want_e2_q;
  assign out_data_o.last_of_run = (rest_mask == '0);

endmodule
